FILE: rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// Box filter downsampler package
// Shared sizes, register indices and the structures that pass between the
// scan counters, the column accumulator store and the averaging unit.
// ----------------------------------------------------------------------------
package bfd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W      = 13;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SUM_W      = 32;
	localparam int TALLY_W    = 25;
	localparam int PIX_W      = 8;
	localparam int CC_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH   = 3'd0,
		REG_SRC_HEIGHT  = 3'd1,
		REG_DST_WIDTH   = 3'd2,
		REG_DST_HEIGHT  = 3'd3,
		REG_CHAN_COUNT  = 3'd4,
		REG_NORMAL_MAP  = 3'd5
	} cfg_reg_t;

	// Effective image sizes after the zero, oversize and upsampling rules.
	typedef struct packed {
		logic [DIM_W-1:0] src_w;
		logic [DIM_W-1:0] src_h;
		logic [DIM_W-1:0] dst_w;
		logic [DIM_W-1:0] dst_h;
	} dims_t;

	// One accepted source pixel with its channels already filled in.
	typedef struct packed {
		logic [PIX_W-1:0] c0;
		logic [PIX_W-1:0] c1;
		logic [PIX_W-1:0] c2;
		logic [PIX_W-1:0] c3;
		logic [COL_W-1:0] oc;
		logic             emit;
		logic             frame_end;
	} pix_item_t;

	// One entry of the column accumulator store.
	typedef struct packed {
		logic [SUM_W-1:0]   sum_r;
		logic [SUM_W-1:0]   sum_g;
		logic [SUM_W-1:0]   sum_b;
		logic [SUM_W-1:0]   sum_a;
		logic [TALLY_W-1:0] tally;
	} acc_entry_t;

	// A finished box handed to the averaging unit.
	typedef struct packed {
		logic [SUM_W-1:0]   sum_r;
		logic [SUM_W-1:0]   sum_g;
		logic [SUM_W-1:0]   sum_b;
		logic [SUM_W-1:0]   sum_a;
		logic [TALLY_W-1:0] tally;
		logic               frame_end;
	} avg_job_t;

	typedef struct packed {
		logic             ready;
		logic [COL_W-1:0] oc;
		logic             emit;
		logic             frame_end;
	} scan_stat_t;

	typedef struct packed {
		logic clearing;
		logic emit_pending;
	} acc_stat_t;

endpackage

FILE: rtl/bfd_scan.sv
// ----------------------------------------------------------------------------
// Box filter downsampler raster scan
// Tracks source and output positions and the box boundaries. Boundaries are
// stepped with a quotient and remainder worked out once per restart.
// ----------------------------------------------------------------------------
module bfd_scan import bfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       restart,
	input  dims_t      dims,
	input  logic       advance,
	output scan_stat_t stat
);

	typedef enum logic {SC_DIV, SC_RUN} scan_state_t;

	localparam int STEP_W = $clog2(DIM_W);

	scan_state_t       state_q;
	logic [STEP_W-1:0] step_q;
	logic [DIM_W-1:0]  cq_q, cr_q, rq_q, rr_q;
	logic [COL_W-1:0]  src_col_q, out_col_q;
	logic [ROW_W-1:0]  src_row_q, out_row_q;
	logic [DIM_W-1:0]  col_bnd_q, col_rem_q, row_bnd_q, row_rem_q;

	logic [DIM_W:0]   col_trial, row_trial;
	logic             col_qbit, row_qbit;
	logic [DIM_W-1:0] col_rem_nx, row_rem_nx;
	logic [DIM_W-1:0] sc1, sr1;
	logic             col_hit, row_hit, line_end, frame_wrap;
	logic [DIM_W:0]   cr_sum, cb_sum, rr_sum, rb_sum;
	logic [DIM_W-1:0] cb_nx, cr_nx, rb_nx, rr_nx;

	// One quotient bit a cycle for both the column and the row ratio.
	always_comb begin
		col_trial  = {cr_q, dims.src_w[step_q]};
		row_trial  = {rr_q, dims.src_h[step_q]};
		col_qbit   = col_trial >= {1'b0, dims.dst_w};
		row_qbit   = row_trial >= {1'b0, dims.dst_h};
		col_rem_nx = col_qbit ? DIM_W'(col_trial - {1'b0, dims.dst_w}) : DIM_W'(col_trial);
		row_rem_nx = row_qbit ? DIM_W'(row_trial - {1'b0, dims.dst_h}) : DIM_W'(row_trial);
	end

	always_comb begin
		sc1        = DIM_W'(src_col_q) + DIM_W'(1);
		sr1        = DIM_W'(src_row_q) + DIM_W'(1);
		col_hit    = sc1 >= col_bnd_q;
		row_hit    = sr1 >= row_bnd_q;
		line_end   = sc1 >= dims.src_w;
		frame_wrap = sr1 >= dims.src_h;
		cr_sum     = (DIM_W+1)'(col_rem_q) + (DIM_W+1)'(cr_q);
		cb_sum     = (DIM_W+1)'(col_bnd_q) + (DIM_W+1)'(cq_q);
		rr_sum     = (DIM_W+1)'(row_rem_q) + (DIM_W+1)'(rr_q);
		rb_sum     = (DIM_W+1)'(row_bnd_q) + (DIM_W+1)'(rq_q);
		if (cr_sum >= (DIM_W+1)'(dims.dst_w)) begin
			cr_nx = DIM_W'(cr_sum - (DIM_W+1)'(dims.dst_w));
			cb_nx = DIM_W'(cb_sum + (DIM_W+1)'(1));
		end else begin
			cr_nx = DIM_W'(cr_sum);
			cb_nx = DIM_W'(cb_sum);
		end
		if (rr_sum >= (DIM_W+1)'(dims.dst_h)) begin
			rr_nx = DIM_W'(rr_sum - (DIM_W+1)'(dims.dst_h));
			rb_nx = DIM_W'(rb_sum + (DIM_W+1)'(1));
		end else begin
			rr_nx = DIM_W'(rr_sum);
			rb_nx = DIM_W'(rb_sum);
		end
	end

	always_comb begin
		stat.ready     = state_q == SC_RUN;
		stat.oc        = out_col_q;
		stat.emit      = col_hit && row_hit;
		stat.frame_end = ((DIM_W'(out_col_q) + DIM_W'(1)) >= dims.dst_w) &&
		                 ((DIM_W'(out_row_q) + DIM_W'(1)) >= dims.dst_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SC_DIV;
			step_q    <= STEP_W'(DIM_W-1);
			cq_q      <= '0;
			cr_q      <= '0;
			rq_q      <= '0;
			rr_q      <= '0;
			src_col_q <= '0;
			out_col_q <= '0;
			src_row_q <= '0;
			out_row_q <= '0;
			col_bnd_q <= '0;
			col_rem_q <= '0;
			row_bnd_q <= '0;
			row_rem_q <= '0;
		end else if (restart) begin
			state_q   <= SC_DIV;
			step_q    <= STEP_W'(DIM_W-1);
			cq_q      <= '0;
			cr_q      <= '0;
			rq_q      <= '0;
			rr_q      <= '0;
		end else begin
			unique case (state_q)
				SC_DIV: begin
					cq_q <= {cq_q[DIM_W-2:0], col_qbit};
					cr_q <= col_rem_nx;
					rq_q <= {rq_q[DIM_W-2:0], row_qbit};
					rr_q <= row_rem_nx;
					if (step_q == '0) begin
						state_q   <= SC_RUN;
						col_bnd_q <= {cq_q[DIM_W-2:0], col_qbit};
						col_rem_q <= col_rem_nx;
						row_bnd_q <= {rq_q[DIM_W-2:0], row_qbit};
						row_rem_q <= row_rem_nx;
						src_col_q <= '0;
						out_col_q <= '0;
						src_row_q <= '0;
						out_row_q <= '0;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				SC_RUN: begin
					if (advance) begin
						if (line_end) begin
							src_col_q <= '0;
							out_col_q <= '0;
							col_bnd_q <= cq_q;
							col_rem_q <= cr_q;
							if (frame_wrap) begin
								src_row_q <= '0;
								out_row_q <= '0;
								row_bnd_q <= rq_q;
								row_rem_q <= rr_q;
							end else begin
								src_row_q <= ROW_W'(sr1);
								if (row_hit) begin
									out_row_q <= out_row_q + ROW_W'(1);
									row_bnd_q <= rb_nx;
									row_rem_q <= rr_nx;
								end
							end
						end else begin
							src_col_q <= COL_W'(sc1);
							if (col_hit) begin
								out_col_q <= out_col_q + COL_W'(1);
								col_bnd_q <= cb_nx;
								col_rem_q <= cr_nx;
							end
						end
					end
				end
				default: state_q <= SC_DIV;
			endcase
		end
	end

	a_advance_running: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> state_q == SC_RUN) else $error("pixel taken before the scan ratios are ready");

endmodule

FILE: rtl/bfd_accum.sv
// ----------------------------------------------------------------------------
// Box filter downsampler column accumulator store
// One entry per output column, read, updated and written back per pixel,
// with forwarding between neighbouring pixels and a clearing sweep on restart.
// ----------------------------------------------------------------------------
module bfd_accum import bfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      restart,
	input  logic      take,
	input  pix_item_t item,
	output acc_stat_t stat,
	output logic      job_valid,
	output avg_job_t  job
);

	acc_entry_t mem [MAX_WIDTH];

	logic             clr_active_q;
	logic [COL_W-1:0] clr_addr_q;
	logic             valid_s1;
	pix_item_t        item_s1;
	acc_entry_t       rdata_s1;
	logic             fwd_s1;
	acc_entry_t       fwd_data_s1;

	acc_entry_t       base, upd, wdata;
	logic             wen;
	logic [COL_W-1:0] waddr;

	always_comb begin
		base      = fwd_s1 ? fwd_data_s1 : rdata_s1;
		upd.sum_r = base.sum_r + SUM_W'(item_s1.c0);
		upd.sum_g = base.sum_g + SUM_W'(item_s1.c1);
		upd.sum_b = base.sum_b + SUM_W'(item_s1.c2);
		upd.sum_a = base.sum_a + SUM_W'(item_s1.c3);
		upd.tally = base.tally + TALLY_W'(1);
		wen       = clr_active_q || valid_s1;
		waddr     = clr_active_q ? clr_addr_q : item_s1.oc;
		wdata     = (clr_active_q || item_s1.emit) ? '0 : upd;
	end

	always_comb begin
		job_valid         = valid_s1 && item_s1.emit;
		job.sum_r         = upd.sum_r;
		job.sum_g         = upd.sum_g;
		job.sum_b         = upd.sum_b;
		job.sum_a         = upd.sum_a;
		job.tally         = upd.tally;
		job.frame_end     = item_s1.frame_end;
		stat.clearing     = clr_active_q;
		stat.emit_pending = valid_s1 && item_s1.emit;
	end

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
		if (take) begin
			rdata_s1 <= mem[item.oc];
			item_s1  <= item;
		end
		fwd_data_s1 <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
		end else if (restart) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			fwd_s1       <= 1'b0;
		end else begin
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + COL_W'(1);
				if (clr_addr_q == COL_W'(MAX_WIDTH-1)) begin
					clr_active_q <= 1'b0;
				end
			end
			valid_s1 <= take;
			// The write of the pixel in flight lands on the same edge as this read.
			fwd_s1   <= take && valid_s1 && (item_s1.oc == item.oc);
		end
	end

	a_no_take_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!(take && clr_active_q)) else $error("pixel taken during the clearing sweep");

	a_jobs_spaced: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |=> !job_valid) else $error("two finished boxes on consecutive cycles");

endmodule

FILE: rtl/bfd_post.sv
// ----------------------------------------------------------------------------
// Box filter downsampler averaging unit
// Divides the box sums by the pixel count, optionally renormalises RGB as a
// unit vector, and holds the finished pixel in the output register.
// ----------------------------------------------------------------------------
module bfd_post import bfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             normal_map,
	input  logic             job_valid,
	input  avg_job_t         job,
	output logic             idle,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] red,
	output logic [PIX_W-1:0] green,
	output logic [PIX_W-1:0] blue,
	output logic [PIX_W-1:0] alpha,
	output logic             frame_end
);

	typedef enum logic [2:0] {
		P_IDLE, P_AVG, P_SQ, P_ROOT, P_PREP, P_RDIV, P_LOAD
	} post_state_t;

	localparam int LANES    = 4;
	localparam int STEP_W   = 5;
	localparam int NORM_W   = 10;
	localparam int SQ_W     = 18;
	localparam int ROOT_W   = 35;
	localparam int ROOT_TOP = 32;
	localparam int LEN_W    = 17;
	localparam int NUM_W    = 28;
	localparam logic signed [NUM_W-1:0] NRM_SCALE = 28'sd65280;
	localparam logic signed [NORM_W-1:0] NRM_BIAS = 10'sd255;

	post_state_t              state_q;
	logic [STEP_W-1:0]        step_q;
	logic [SUM_W-1:0]         rem_q [LANES];
	logic [SUM_W-1:0]         dsh_q;
	logic [PIX_W-1:0]         quo_q [LANES];
	logic [2:0]               sat_q;
	logic signed [NORM_W-1:0] n_q [3];
	logic [ROOT_W-1:0]        rx_q, rr_q, rbit_q;
	logic                     fe_q, normal_q;
	logic                     out_valid_q;
	logic [PIX_W-1:0]         red_q, green_q, blue_q, alpha_q;
	logic                     frame_end_q;

	logic                       div_ge [LANES];
	logic signed [NORM_W-1:0]   n_nx [3];
	logic signed [2*NORM_W-1:0] sq [3];
	logic [SQ_W-1:0]            sq_sum;
	logic [ROOT_W-1:0]          root_trial;
	logic                       root_ge;
	logic [LEN_W-1:0]           len;
	logic signed [NUM_W-1:0]    num [3];
	logic [TALLY_W-1:0]         cnt_eff;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			div_ge[l] = rem_q[l] >= dsh_q;
		end
		for (int k = 0; k < 3; k++) begin
			n_nx[k] = $signed({1'b0, quo_q[k], 1'b0}) - NRM_BIAS;
			sq[k]   = n_nx[k] * n_nx[k];
		end
		sq_sum = SQ_W'($unsigned(sq[0])) + SQ_W'($unsigned(sq[1])) +
		         SQ_W'($unsigned(sq[2]));
		root_trial = rr_q + rbit_q;
		root_ge    = rx_q >= root_trial;
		len        = rr_q[LEN_W-1:0];
		// 255*(256n + L) + L folds to 65280n + 256L.
		for (int k = 0; k < 3; k++) begin
			num[k] = NUM_W'(n_q[k]) * NRM_SCALE + $signed(NUM_W'({len, 8'b0}));
		end
		cnt_eff = (job.tally == '0) ? TALLY_W'(1) : job.tally;
	end

	assign idle      = state_q == P_IDLE;
	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign alpha     = alpha_q;
	assign frame_end = frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= P_IDLE;
			step_q      <= '0;
			dsh_q       <= '0;
			sat_q       <= '0;
			rx_q        <= '0;
			rr_q        <= '0;
			rbit_q      <= '0;
			fe_q        <= 1'b0;
			normal_q    <= 1'b0;
			out_valid_q <= 1'b0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			alpha_q     <= '0;
			frame_end_q <= 1'b0;
			for (int l = 0; l < LANES; l++) begin
				rem_q[l] <= '0;
				quo_q[l] <= '0;
			end
			for (int k = 0; k < 3; k++) begin
				n_q[k] <= '0;
			end
		end else begin
			// While loading, the load arm below decides the output valid bit.
			if (out_valid_q && out_ready && state_q != P_LOAD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				P_IDLE: begin
					if (job_valid) begin
						rem_q[0] <= job.sum_r;
						rem_q[1] <= job.sum_g;
						rem_q[2] <= job.sum_b;
						rem_q[3] <= job.sum_a;
						dsh_q    <= {cnt_eff, 7'b0};
						step_q   <= STEP_W'(PIX_W-1);
						fe_q     <= job.frame_end;
						normal_q <= normal_map;
						state_q  <= P_AVG;
						for (int l = 0; l < LANES; l++) begin
							quo_q[l] <= '0;
						end
					end
				end
				P_AVG, P_RDIV: begin
					for (int l = 0; l < LANES; l++) begin
						if (l < 3 || state_q == P_AVG) begin
							quo_q[l] <= {quo_q[l][PIX_W-2:0], div_ge[l]};
							if (div_ge[l]) begin
								rem_q[l] <= rem_q[l] - dsh_q;
							end
						end
					end
					dsh_q <= dsh_q >> 1;
					if (step_q == '0) begin
						state_q <= (state_q == P_AVG && normal_q) ? P_SQ : P_LOAD;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				P_SQ: begin
					for (int k = 0; k < 3; k++) begin
						n_q[k] <= n_nx[k];
					end
					rx_q    <= ROOT_W'({sq_sum, 16'b0});
					rr_q    <= '0;
					rbit_q  <= ROOT_W'(1) << ROOT_TOP;
					step_q  <= STEP_W'(ROOT_TOP/2);
					state_q <= P_ROOT;
				end
				P_ROOT: begin
					if (root_ge) begin
						rx_q <= rx_q - root_trial;
						rr_q <= (rr_q >> 1) + rbit_q;
					end else begin
						rr_q <= rr_q >> 1;
					end
					rbit_q <= rbit_q >> 2;
					if (step_q == '0) begin
						state_q <= P_PREP;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				P_PREP: begin
					for (int k = 0; k < 3; k++) begin
						rem_q[k] <= num[k][NUM_W-1] ? '0 : SUM_W'($unsigned(num[k]));
						sat_q[k] <= !num[k][NUM_W-1] &&
						            ($unsigned(num[k]) >= NUM_W'({len, 9'b0}));
						quo_q[k] <= '0;
					end
					dsh_q   <= SUM_W'({len, 8'b0});
					step_q  <= STEP_W'(PIX_W-1);
					state_q <= P_RDIV;
				end
				P_LOAD: begin
					if (!out_valid_q || out_ready) begin
						red_q       <= (normal_q && sat_q[0]) ? '1 : quo_q[0];
						green_q     <= (normal_q && sat_q[1]) ? '1 : quo_q[1];
						blue_q      <= (normal_q && sat_q[2]) ? '1 : quo_q[2];
						alpha_q     <= quo_q[3];
						frame_end_q <= fe_q;
						out_valid_q <= 1'b1;
						state_q     <= P_IDLE;
					end
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	a_job_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> state_q == P_IDLE) else $error("finished box arrived while busy");

endmodule

FILE: rtl/box_filter_downsampler_top.sv
// ----------------------------------------------------------------------------
// Box filter downsampler
// Streams source pixels in raster order and produces a box-averaged RGBA8
// image of the configured smaller size, with optional normal-map
// renormalisation of the averaged RGB.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  --------------------------------------
//  config    cfg_write              cfg_index, cfg_data (no wait, no read)
//  pixels    in_valid / in_ready    chan0, chan1, chan2, chan3
//  results   out_valid / out_ready  red, green, blue, alpha, frame_end
//
// Source pixels that complete no box are taken back to back, the column store
// forwarding between neighbours.
// A pixel that completes a box is taken only once the averaging unit is free;
// that unit works through eight divide steps, or in normal-map mode through eight
// divide steps, a 17-step square root and eight more divide steps.
// After reset and after every write to a known register index the column
// store is swept clear, and in_ready stays low during the sweep.
// The output register lets the next box be worked on while a result waits.
//
module box_filter_downsampler_top import bfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIX_W-1:0]      chan0,
	input  logic [PIX_W-1:0]      chan1,
	input  logic [PIX_W-1:0]      chan2,
	input  logic [PIX_W-1:0]      chan3,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIX_W-1:0]      red,
	output logic [PIX_W-1:0]      green,
	output logic [PIX_W-1:0]      blue,
	output logic [PIX_W-1:0]      alpha,
	output logic                  frame_end
);

	// Configuration registers, held as written; the size rules are applied below.
	logic [DIM_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [CC_W-1:0]  channel_count_q;
	logic             normal_map_q;
	// One-cycle pulse that restarts the frame; set by reset so the first
	// clearing sweep and ratio division run straight after it.
	logic             restart_q;
	logic             cfg_known;

	dims_t      dims;
	logic [CC_W-1:0] cc_eff;
	pix_item_t  item;
	scan_stat_t scan_stat;
	acc_stat_t  acc_stat;
	logic       take;
	logic       job_valid;
	avg_job_t   job;
	logic       post_idle;

	assign cfg_known = cfg_index <= REG_NORMAL_MAP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= DIM_W'(1);
			src_height_q    <= DIM_W'(1);
			dst_width_q     <= DIM_W'(1);
			dst_height_q    <= DIM_W'(1);
			channel_count_q <= CC_W'(4);
			normal_map_q    <= 1'b0;
			restart_q       <= 1'b1;
		end else begin
			restart_q <= cfg_write && cfg_known;
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SRC_WIDTH:  src_width_q     <= cfg_data[DIM_W-1:0];
					REG_SRC_HEIGHT: src_height_q    <= cfg_data[DIM_W-1:0];
					REG_DST_WIDTH:  dst_width_q     <= cfg_data[DIM_W-1:0];
					REG_DST_HEIGHT: dst_height_q    <= cfg_data[DIM_W-1:0];
					REG_CHAN_COUNT: channel_count_q <= cfg_data[CC_W-1:0];
					REG_NORMAL_MAP: normal_map_q    <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// A zero size acts as one, an oversize source saturates, and an output
	// larger than the source is cut down to the source size.
	always_comb begin
		if (src_width_q == '0) begin
			dims.src_w = DIM_W'(1);
		end else if (src_width_q > DIM_W'(MAX_WIDTH)) begin
			dims.src_w = DIM_W'(MAX_WIDTH);
		end else begin
			dims.src_w = src_width_q;
		end
		if (src_height_q == '0) begin
			dims.src_h = DIM_W'(1);
		end else if (src_height_q > DIM_W'(MAX_HEIGHT)) begin
			dims.src_h = DIM_W'(MAX_HEIGHT);
		end else begin
			dims.src_h = src_height_q;
		end
		if (dst_width_q == '0) begin
			dims.dst_w = DIM_W'(1);
		end else if (dst_width_q > dims.src_w) begin
			dims.dst_w = dims.src_w;
		end else begin
			dims.dst_w = dst_width_q;
		end
		if (dst_height_q == '0) begin
			dims.dst_h = DIM_W'(1);
		end else if (dst_height_q > dims.src_h) begin
			dims.dst_h = dims.src_h;
		end else begin
			dims.dst_h = dst_height_q;
		end
	end

	// Channel fill: a zero count or one above four means four channels;
	// missing colour channels copy channel 0 and missing alpha is opaque.
	always_comb begin
		cc_eff = (channel_count_q == '0 || channel_count_q > CC_W'(4)) ?
		         CC_W'(4) : channel_count_q;
		item.c0        = chan0;
		item.c1        = (cc_eff > CC_W'(1)) ? chan1 : chan0;
		item.c2        = (cc_eff > CC_W'(2)) ? chan2 : chan0;
		item.c3        = (cc_eff > CC_W'(3)) ? chan3 : '1;
		item.oc        = scan_stat.oc;
		item.emit      = scan_stat.emit;
		item.frame_end = scan_stat.frame_end;
	end

	// A pixel that closes a box needs the averaging unit free and no other
	// finished box still on its way from the column store.
	assign in_ready = scan_stat.ready && !acc_stat.clearing && !restart_q &&
	                  (!scan_stat.emit || (post_idle && !acc_stat.emit_pending));
	assign take     = in_valid && in_ready;

	bfd_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart_q),
		.dims    (dims),
		.advance (take),
		.stat    (scan_stat)
	);

	bfd_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart_q),
		.take      (take),
		.item      (item),
		.stat      (acc_stat),
		.job_valid (job_valid),
		.job       (job)
	);

	bfd_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.normal_map (normal_map_q),
		.job_valid  (job_valid),
		.job        (job),
		.idle       (post_idle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.frame_end  (frame_end)
	);

endmodule

FILE: bench/tb_box_filter_downsampler_top.sv
// ----------------------------------------------------------------------------
// Box filter downsampler testbench
// Streams raster frames through the block under a range of image sizes,
// channel counts and normal-map settings. A behavioural model of the column
// accumulators predicts every output pixel, and the monitor compares each
// output transfer with the oldest prediction while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_box_filter_downsampler_top;
	import bfd_pkg::*;

	// Indices beyond the register list, which the block must ignore.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Ample for the slowest legal run: store sweeps after register writes, the
	// normal-map path of the averaging unit and a receiver that accepts one cycle in seven.
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_ITEMS = 1600;

	typedef struct packed {
		logic [PIX_W-1:0] c0;
		logic [PIX_W-1:0] c1;
		logic [PIX_W-1:0] c2;
		logic [PIX_W-1:0] c3;
	} src_pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] alpha;
		logic             frame_end;
	} box_pix_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [PIX_W-1:0]      chan0 = '0;
	logic [PIX_W-1:0]      chan1 = '0;
	logic [PIX_W-1:0]      chan2 = '0;
	logic [PIX_W-1:0]      chan3 = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PIX_W-1:0]      red;
	logic [PIX_W-1:0]      green;
	logic [PIX_W-1:0]      blue;
	logic [PIX_W-1:0]      alpha;
	logic                  frame_end;

	box_filter_downsampler_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.chan0     (chan0),
		.chan1     (chan1),
		.chan2     (chan2),
		.chan3     (chan3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.frame_end (frame_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow copy of the configuration and of the block's scan state.
	logic [DIM_W-1:0] m_src_w, m_src_h, m_dst_w, m_dst_h;
	logic [CC_W-1:0]  m_chans;
	logic             m_normal;
	int unsigned acc_r[MAX_WIDTH];
	int unsigned acc_g[MAX_WIDTH];
	int unsigned acc_b[MAX_WIDTH];
	int unsigned acc_a[MAX_WIDTH];
	int unsigned acc_n[MAX_WIDTH];
	int unsigned scan_col, scan_row, box_col, box_row, col_edge, row_edge;

	src_pix_t pixel_backlog[$];
	box_pix_t pending_boxes[$];

	int unsigned cycles = 0;
	int          mismatches = 0;
	int          send_idle = 0;
	int          recv_idle = 0;

	function automatic int unsigned eff_src(int unsigned v, int unsigned cap);
		if (v == 0) return 1;
		return (v > cap) ? cap : v;
	endfunction

	function automatic int unsigned eff_dst(int unsigned v, int unsigned src);
		if (v == 0) return 1;
		return (v > src) ? src : v;
	endfunction

	function automatic logic [63:0] root64(logic [63:0] x);
		logic [63:0] r, bit_mask;
		r = 0;
		bit_mask = 64'd1 << 62;
		while (bit_mask > x) bit_mask = bit_mask >> 2;
		while (bit_mask != 0) begin
			if (x >= r + bit_mask) begin
				x = x - (r + bit_mask);
				r = (r >> 1) + bit_mask;
			end else begin
				r = r >> 1;
			end
			bit_mask = bit_mask >> 2;
		end
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] unit_scale(longint n, longint len);
		longint num;
		num = 255 * (256 * n + len) + len;
		if (num < 0) return '0;
		num = num / (2 * len);
		return (num > 255) ? 8'd255 : num[7:0];
	endfunction

	// A restart clears every column and rewinds the scan to the first box.
	task automatic rewind_frame();
		int unsigned sw, sh;
		sw = eff_src(m_src_w, MAX_WIDTH);
		sh = eff_src(m_src_h, MAX_HEIGHT);
		for (int i = 0; i < MAX_WIDTH; i++) begin
			acc_r[i] = 0; acc_g[i] = 0; acc_b[i] = 0; acc_a[i] = 0; acc_n[i] = 0;
		end
		scan_col = 0; scan_row = 0; box_col = 0; box_row = 0;
		col_edge = sw / eff_dst(m_dst_w, sw);
		row_edge = sh / eff_dst(m_dst_h, sh);
	endtask

	// Adds one source pixel to its column and, when it closes a box,
	// queues the averaged output pixel.
	task automatic absorb_pixel(src_pix_t p);
		int unsigned sw, sh, dw, dh, cc, oc, cnt;
		logic [PIX_W-1:0] v1, v2, v3;
		longint nr, ng, nb, len;
		logic [63:0] sq;
		box_pix_t bx;
		sw = eff_src(m_src_w, MAX_WIDTH);
		sh = eff_src(m_src_h, MAX_HEIGHT);
		dw = eff_dst(m_dst_w, sw);
		dh = eff_dst(m_dst_h, sh);
		cc = (m_chans == 0) ? 4 : m_chans;
		v1 = (cc > 1) ? p.c1 : p.c0;
		v2 = (cc > 2) ? p.c2 : p.c0;
		v3 = (cc > 3) ? p.c3 : 8'd255;
		oc = box_col % MAX_WIDTH;
		acc_r[oc] += p.c0;
		acc_g[oc] += v1;
		acc_b[oc] += v2;
		acc_a[oc] += v3;
		acc_n[oc] = (acc_n[oc] + 1) & 32'h1FF_FFFF;
		if (scan_col + 1 >= col_edge && scan_row + 1 >= row_edge) begin
			cnt = (acc_n[oc] == 0) ? 1 : acc_n[oc];
			bx.red   = 8'(acc_r[oc] / cnt);
			bx.green = 8'(acc_g[oc] / cnt);
			bx.blue  = 8'(acc_b[oc] / cnt);
			bx.alpha = 8'(acc_a[oc] / cnt);
			if (m_normal) begin
				nr = 2 * longint'(bx.red) - 255;
				ng = 2 * longint'(bx.green) - 255;
				nb = 2 * longint'(bx.blue) - 255;
				sq = 64'(nr * nr + ng * ng + nb * nb);
				len = longint'(root64(sq * 65536));
				if (len < 1) len = 1;
				bx.red   = unit_scale(nr, len);
				bx.green = unit_scale(ng, len);
				bx.blue  = unit_scale(nb, len);
			end
			bx.frame_end = (box_col + 1 >= dw && box_row + 1 >= dh);
			pending_boxes.push_back(bx);
			acc_r[oc] = 0; acc_g[oc] = 0; acc_b[oc] = 0; acc_a[oc] = 0; acc_n[oc] = 0;
		end
		scan_col++;
		if (scan_col >= col_edge) begin
			box_col++;
			col_edge = ((box_col + 1) * sw) / dw;
		end
		if (scan_col >= sw) begin
			scan_col = 0;
			box_col = 0;
			col_edge = sw / dw;
			scan_row++;
			if (scan_row >= row_edge) begin
				box_row++;
				row_edge = ((box_row + 1) * sh) / dh;
			end
			if (scan_row >= sh) begin
				scan_row = 0;
				box_row = 0;
				row_edge = sh / dh;
			end
		end
	endtask

	// Source driver. The payload is only reloaded once the previous transfer
	// has happened, so valid and data hold steady while the block stalls.
	always @(posedge clk) begin
		src_pix_t p;
		logic calm;
		calm = (cycles % 256) >= 192;
		if (!in_valid || in_ready) begin
			if (arst_n && pixel_backlog.size() != 0 &&
			    (calm || $urandom_range(0, 99) >= send_idle)) begin
				p = pixel_backlog.pop_front();
				in_valid <= 1'b1;
				chan0 <= p.c0;
				chan1 <= p.c1;
				chan2 <= p.c2;
				chan3 <= p.c3;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor. Input transfers feed the model; output transfers are checked
	// against the oldest prediction.
	always @(posedge clk) begin
		box_pix_t want;
		box_pix_t got;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
		out_ready <= ((cycles % 256) >= 192) || ($urandom_range(0, 99) >= recv_idle);
		if (arst_n && in_valid && in_ready)
			absorb_pixel('{chan0, chan1, chan2, chan3});
		if (arst_n && out_valid && out_ready) begin
			got = '{red, green, blue, alpha, frame_end};
			if (pending_boxes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output pixel %h", got);
			end else begin
				want = pending_boxes.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected r%0d g%0d b%0d a%0d fe%0d, got r%0d g%0d b%0d a%0d fe%0d",
							want.red, want.green, want.blue, want.alpha, want.frame_end,
							got.red, got.green, got.blue, got.alpha, got.frame_end);
				end
			end
		end
	end

	// Waits until every pixel has been transferred and every prediction has
	// been met, then lets the averaging pipeline run dry.
	task automatic drain();
		while (pixel_backlog.size() != 0 || in_valid || pending_boxes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_SRC_WIDTH:  m_src_w = val;
			REG_SRC_HEIGHT: m_src_h = val;
			REG_DST_WIDTH:  m_dst_w = val;
			REG_DST_HEIGHT: m_dst_h = val;
			REG_CHAN_COUNT: m_chans = val[CC_W-1:0];
			REG_NORMAL_MAP: m_normal = val[0];
			default: ;
		endcase
		if (idx <= REG_NORMAL_MAP) rewind_frame();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] level();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic src_pix_t random_pixel();
		return '{level(), level(), level(), level()};
	endfunction

	initial begin
		int random_sent;
		int sw, sh, n;
		m_src_w = 1; m_src_h = 1; m_dst_w = 1; m_dst_h = 1;
		m_chans = 4; m_normal = 1'b0;
		rewind_frame();
		send_idle = 28;
		recv_idle = 86;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: every pixel is a box of its own, so the extremes
		// of each channel come straight back.
		pixel_backlog.push_back('{8'd0, 8'd0, 8'd0, 8'd0});
		pixel_backlog.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
		pixel_backlog.push_back('{8'd255, 8'd0, 8'd255, 8'd0});
		pixel_backlog.push_back('{8'd0, 8'd255, 8'd0, 8'd255});
		pixel_backlog.push_back('{8'd1, 8'd128, 8'd127, 8'd254});
		drain();

		// Normal-map mode, with the components closest to zero and the
		// all-zero and all-full colours.
		write_reg(REG_NORMAL_MAP, 13'd1);
		pixel_backlog.push_back('{8'd127, 8'd128, 8'd127, 8'd9});
		pixel_backlog.push_back('{8'd128, 8'd128, 8'd128, 8'd0});
		pixel_backlog.push_back('{8'd0, 8'd0, 8'd0, 8'd255});
		pixel_backlog.push_back('{8'd255, 8'd255, 8'd255, 8'd77});
		pixel_backlog.push_back('{8'd255, 8'd127, 8'd0, 8'd200});
		pixel_backlog.push_back('{8'd128, 8'd128, 8'd255, 8'd128});
		drain();

		// Single-channel source: green and blue follow channel 0 and alpha
		// reads full.
		write_reg(REG_NORMAL_MAP, 13'd0);
		write_reg(REG_CHAN_COUNT, 13'd1);
		pixel_backlog.push_back('{8'd200, 8'd3, 8'd4, 8'd5});
		pixel_backlog.push_back('{8'd17, 8'd255, 8'd255, 8'd0});
		drain();

		// Oversize source width saturates at the maximum, so a half-width
		// output pairs neighbouring columns into each box.
		write_reg(REG_SRC_WIDTH, 13'd8191);
		write_reg(REG_DST_WIDTH, 13'd2048);
		write_reg(REG_CHAN_COUNT, 13'd0);
		for (int i = 0; i < 64; i++) pixel_backlog.push_back(random_pixel());
		drain();

		// Full-width output, oversize height asking to upsample, zero source
		// height and ignored register indices.
		write_reg(REG_DST_WIDTH, 13'd4096);
		write_reg(REG_SRC_HEIGHT, 13'd0);
		write_reg(REG_DST_HEIGHT, 13'd8191);
		write_reg(REG_SPARE_LO, 13'd5);
		write_reg(REG_SPARE_HI, 13'd8191);
		for (int i = 0; i < 20; i++) pixel_backlog.push_back(random_pixel());
		drain();

		// Random phases of whole frames with a partial frame now and then.
		random_sent = 0;
		for (int phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
			if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0; recv_idle = 0;
			end else if (random_sent >= RANDOM_ITEMS / 3) begin
				send_idle = 86; recv_idle = 28;
			end
			sw = $urandom_range(1, 24);
			sh = $urandom_range(1, 10);
			write_reg(REG_SRC_WIDTH, 13'(sw));
			write_reg(REG_SRC_HEIGHT, 13'(sh));
			case ($urandom_range(0, 5))
				0: write_reg(REG_DST_WIDTH, 13'd0);
				1: write_reg(REG_DST_WIDTH, 13'($urandom_range(sw, sw + 40)));
				default: write_reg(REG_DST_WIDTH, 13'($urandom_range(1, sw)));
			endcase
			case ($urandom_range(0, 5))
				0: write_reg(REG_DST_HEIGHT, 13'd0);
				1: write_reg(REG_DST_HEIGHT, 13'($urandom_range(sh, 8191)));
				default: write_reg(REG_DST_HEIGHT, 13'($urandom_range(1, sh)));
			endcase
			write_reg(REG_CHAN_COUNT, 13'($urandom_range(0, 7)));
			write_reg(REG_NORMAL_MAP, 13'($urandom_range(0, 1)));
			n = sw * sh * $urandom_range(1, 2);
			if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
			for (int i = 0; i < n; i++) begin
				// Once, hold the source back until the block has caught up.
				if (phase == 3 && i == n / 2) drain();
				pixel_backlog.push_back(random_pixel());
			end
			random_sent += n;
			drain();
		end

		mismatches += pending_boxes.size();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
